FILE: sv/catmull_rom_curve_point_defines.svh
// assertion macros shared by the curve point block
`ifndef CATMULL_ROM_CURVE_POINT_DEFINES_SVH
`define CATMULL_ROM_CURVE_POINT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CRCV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CRCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/crcv_pkg.sv
package crcv_pkg;

    // table and field geometry
    localparam int MaxPoints = 256;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CoordW    = 24;
    localparam int TW        = 17;
    localparam int LenW      = 9;
    localparam int FracW     = 16;
    localparam int SpanW     = 8;
    localparam int Lanes     = 4;

    // weight arithmetic widths
    localparam int U2W     = 2 * FracW;
    localparam int U3W     = 3 * FracW;
    localparam int WideW   = U3W + 4;
    localparam int RoundSh = 25;
    localparam int WqW     = WideW - RoundSh;
    localparam int PrdW    = CoordW + WqW;
    localparam int SumW    = PrdW + 2;
    localparam int OutSh   = 24;
    localparam int RsW     = SumW - OutSh;

    localparam logic [TW-1:0]   OneQ16        = 17'h1_0000;
    localparam logic [LenW-1:0] LenMin        = 9'd4;
    localparam logic [LenW-1:0] SpanOff       = 9'd3;
    localparam logic [LenW-1:0] PointCountRst = 9'd4;

    // twice the constant term of the middle weight, and the rounding bias
    localparam logic signed [WideW-1:0] TwoP48 =
        {{(WideW - U3W - 2){1'b0}}, 2'b10, {U3W{1'b0}}};
    localparam logic signed [WideW-1:0] RndW =
        {{(WideW - RoundSh){1'b0}}, 1'b1, {(RoundSh - 1){1'b0}}};
    localparam logic signed [SumW-1:0] RndOut =
        {{(SumW - OutSh){1'b0}}, 1'b1, {(OutSh - 1){1'b0}}};
    localparam logic [WqW-1:0] WqOne = {{(WqW - OutSh - 1){1'b0}}, 1'b1, {OutSh{1'b0}}};
    localparam logic [CoordW-1:0] SatMax = 24'h7F_FFFF;
    localparam logic [CoordW-1:0] SatMin = 24'h80_0000;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } t_req;

    // item after span split
    typedef struct packed {
        t_req              req;
        logic [IdxW-1:0]   point_index;
        logic [CoordW-1:0] px;
        logic [CoordW-1:0] py;
        logic [SpanW-1:0]  span;
        logic [IdxW-1:0]   offset;
        logic              full;
        logic [FracW-1:0]  u;
    } t_span_item;

    // item after point fetch
    typedef struct packed {
        logic [Lanes-1:0][CoordW-1:0] px;
        logic [Lanes-1:0][CoordW-1:0] py;
        logic [U2W-1:0]               u2;
        logic [FracW-1:0]             u;
        logic                         full;
    } t_fetch_item;

endpackage

FILE: sv/crcv_if.sv
interface crcv_req_if
    import crcv_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [IdxW-1:0]          point_index;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic [TW-1:0]            curve_t;
    logic [LenW-1:0]          segment_points;
    logic [IdxW-1:0]          start_offset;

    modport source (output valid, req_type, point_index, point_x, point_y, curve_t,
                    segment_points, start_offset, input ready);
    modport sink   (input valid, req_type, point_index, point_x, point_y, curve_t,
                    segment_points, start_offset, output ready);
endinterface

interface crcv_res_if
    import crcv_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [CoordW-1:0] curve_x;
    logic signed [CoordW-1:0] curve_y;

    modport source (output valid, curve_x, curve_y, input ready);
    modport sink   (input valid, curve_x, curve_y, output ready);
endinterface

interface crcv_cfg_if
    import crcv_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [LenW-1:0] point_count;

    modport source (output valid, point_count, input ready);
    modport sink   (input valid, point_count, output ready);
endinterface

FILE: sv/crcv_span.sv
module crcv_span
    import crcv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    crcv_req_if.sink      i_req,
    output logic          o_s1_vld,
    output t_span_item    o_s1,
    input  logic          i_s1_rdy
);

    logic                      r_vld;
    t_span_item                r_s1;
    t_span_item                n_s1;
    logic                      en;
    logic                      full;
    logic [LenW-1:0]           len_c;
    logic [LenW-1:0]           spans;
    logic [FracW+LenW-1:0]     prod;

    assign en          = !r_vld || i_s1_rdy;
    assign i_req.ready = en;

    // clamp t and length, scale t across the spans
    assign full  = (i_req.curve_t >= OneQ16);
    assign len_c = (i_req.segment_points < LenMin) ? LenMin : i_req.segment_points;
    assign spans = len_c - SpanOff;
    assign prod  = i_req.curve_t[FracW-1:0] * spans;

    always_comb begin
        n_s1.req         = t_req'(i_req.req_type);
        n_s1.point_index = i_req.point_index;
        n_s1.px          = i_req.point_x;
        n_s1.py          = i_req.point_y;
        n_s1.offset      = i_req.start_offset;
        n_s1.full        = full;
        if (full) begin
            n_s1.span = SpanW'(len_c - LenMin);
            n_s1.u    = '0;
        end else begin
            n_s1.span = prod[FracW+SpanW-1:FracW];
            n_s1.u    = prod[FracW-1:0];
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_vld = r_vld;
    assign o_s1     = r_s1;

endmodule

FILE: sv/crcv_fetch.sv
module crcv_fetch
    import crcv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [LenW-1:0] i_point_count,
    input  logic            i_s1_vld,
    input  t_span_item      i_s1,
    output logic            o_s1_rdy,
    output logic            o_s2_vld,
    output t_fetch_item     o_s2,
    input  logic            i_s2_rdy
);

    logic              r_vld;
    logic [U2W-1:0]    r_u2;
    logic [FracW-1:0]  r_u;
    logic              r_full;
    logic              en;
    logic              wr_en;
    logic [LenW-1:0]   base;
    logic [LenW-1:0]   raw   [Lanes];
    logic [LenW-1:0]   wrap  [Lanes];
    logic [IdxW-1:0]   rd_idx [Lanes];
    logic [CoordW-1:0] rd_x  [Lanes];
    logic [CoordW-1:0] rd_y  [Lanes];

    assign en       = !r_vld || i_s2_rdy;
    assign o_s1_rdy = en;
    assign wr_en    = en && i_s1_vld && (i_s1.req == REQ_LOAD);

    // four consecutive indices, wrapped once by the point count
    assign base = LenW'(i_s1.span) + LenW'(i_s1.offset);
    always_comb begin
        for (int k = 0; k < Lanes; k++) begin
            raw[k]    = base + LenW'(k);
            wrap[k]   = (raw[k] >= i_point_count) ? raw[k] - i_point_count : raw[k];
            rd_idx[k] = wrap[k][IdxW-1:0];
        end
    end

    // one table copy per lane, all written together by loads
    for (genvar k = 0; k < Lanes; k++) begin : g_bank
        logic [2*CoordW-1:0] r_bank [MaxPoints];
        logic [2*CoordW-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_bank[i_s1.point_index] <= {i_s1.px, i_s1.py};
            end
            if (en) begin
                r_rd <= r_bank[rd_idx[k]];
            end
        end

        assign rd_x[k] = r_rd[2*CoordW-1:CoordW];
        assign rd_y[k] = r_rd[CoordW-1:0];
    end

    // square of the fraction alongside the fetch
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u2   <= i_s1.u * i_s1.u;
            r_u    <= i_s1.u;
            r_full <= i_s1.full;
        end
    end

    // loads end here, only evaluations travel on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_s1_vld && (i_s1.req == REQ_EVAL);
        end
    end

    always_comb begin
        for (int k = 0; k < Lanes; k++) begin
            o_s2.px[k] = rd_x[k];
            o_s2.py[k] = rd_y[k];
        end
        o_s2.u2   = r_u2;
        o_s2.u    = r_u;
        o_s2.full = r_full;
    end

    assign o_s2_vld = r_vld;

endmodule

FILE: sv/crcv_blend.sv
`include "catmull_rom_curve_point_defines.svh"

module crcv_blend
    import crcv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s2_vld,
    input  t_fetch_item i_s2,
    output logic        o_s2_rdy,
    crcv_res_if.source  o_res
);

    // stage 3: cube of the fraction
    logic                         r3_vld;
    logic [U3W-1:0]               r3_u3;
    logic [U2W-1:0]               r3_u2;
    logic [FracW-1:0]             r3_u;
    logic                         r3_full;
    logic [Lanes-1:0][CoordW-1:0] r3_px;
    logic [Lanes-1:0][CoordW-1:0] r3_py;
    // stage 4: weights in Q0.24
    logic                         r4_vld;
    logic [Lanes-1:0][WqW-1:0]    r4_wq;
    logic [Lanes-1:0][CoordW-1:0] r4_px;
    logic [Lanes-1:0][CoordW-1:0] r4_py;
    // stage 5: products
    logic                         r5_vld;
    logic [Lanes-1:0][PrdW-1:0]   r5_prdx;
    logic [Lanes-1:0][PrdW-1:0]   r5_prdy;
    // output register
    logic                         r_out_vld;
    logic [CoordW-1:0]            r_out_x;
    logic [CoordW-1:0]            r_out_y;

    logic                         en3;
    logic                         en4;
    logic                         en5;
    logic                         en_out;
    logic signed [WideW-1:0]      ta;
    logic signed [WideW-1:0]      tb;
    logic signed [WideW-1:0]      tc;
    logic signed [WideW-1:0]      w    [Lanes];
    logic signed [WideW-1:0]      wr   [Lanes];
    logic [Lanes-1:0][WqW-1:0]    n_wq;
    logic signed [SumW-1:0]       sum_x;
    logic signed [SumW-1:0]       sum_y;
    logic signed [SumW-1:0]       rnd_x;
    logic signed [SumW-1:0]       rnd_y;
    logic [RsW-1:0]               rs_x;
    logic [RsW-1:0]               rs_y;
    logic [CoordW-1:0]            n_out_x;
    logic [CoordW-1:0]            n_out_y;
    logic signed [RsW-1:0]        wq_sum;

    assign en_out   = !r_out_vld || o_res.ready;
    assign en5      = !r5_vld || en_out;
    assign en4      = !r4_vld || en5;
    assign en3      = !r3_vld || en4;
    assign o_s2_rdy = en3;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (en3) begin
                r3_vld <= i_s2_vld;
            end
            if (en4) begin
                r4_vld <= r3_vld;
            end
            if (en5) begin
                r5_vld <= r4_vld;
            end
            if (en_out) begin
                r_out_vld <= r5_vld;
            end
        end
    end

    // cube of the fraction
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_u3   <= i_s2.u2 * i_s2.u;
            r3_u2   <= i_s2.u2;
            r3_u    <= i_s2.u;
            r3_full <= i_s2.full;
            r3_px   <= i_s2.px;
            r3_py   <= i_s2.py;
        end
    end

    // twice each weight scaled by 2^48, rounded half up to Q0.24
    assign ta = $signed({4'b0, r3_u3});
    assign tb = $signed({4'b0, r3_u2, {FracW{1'b0}}});
    assign tc = $signed({4'b0, r3_u, {U2W{1'b0}}});

    always_comb begin
        w[0] = (tb <<< 1) - ta - tc;
        w[1] = (ta <<< 1) + ta - (tb <<< 2) - tb + TwoP48;
        w[2] = (tb <<< 2) - (ta <<< 1) - ta + tc;
        w[3] = ta - tb;
        for (int k = 0; k < Lanes; k++) begin
            wr[k]   = w[k] + RndW;
            n_wq[k] = wr[k][WideW-1:RoundSh];
        end
        // at t of one the curve sits exactly on the third point
        if (r3_full) begin
            n_wq    = '0;
            n_wq[2] = WqOne;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_wq <= n_wq;
            r4_px <= r3_px;
            r4_py <= r3_py;
        end
    end

    // point times weight, one multiplier per lane and axis
    always_ff @(posedge i_clk) begin
        if (en5) begin
            for (int k = 0; k < Lanes; k++) begin
                r5_prdx[k] <= $signed(r4_px[k]) * $signed(r4_wq[k]);
                r5_prdy[k] <= $signed(r4_py[k]) * $signed(r4_wq[k]);
            end
        end
    end

    // sum, round to Q16.8 and saturate
    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int k = 0; k < Lanes; k++) begin
            sum_x = sum_x + SumW'($signed(r5_prdx[k]));
            sum_y = sum_y + SumW'($signed(r5_prdy[k]));
        end
        rnd_x = sum_x + RndOut;
        rnd_y = sum_y + RndOut;
        rs_x  = rnd_x[SumW-1:OutSh];
        rs_y  = rnd_y[SumW-1:OutSh];
        if (rs_x[RsW-1:CoordW-1] == '0 || rs_x[RsW-1:CoordW-1] == '1) begin
            n_out_x = rs_x[CoordW-1:0];
        end else begin
            n_out_x = rs_x[RsW-1] ? SatMin : SatMax;
        end
        if (rs_y[RsW-1:CoordW-1] == '0 || rs_y[RsW-1:CoordW-1] == '1) begin
            n_out_y = rs_y[CoordW-1:0];
        end else begin
            n_out_y = rs_y[RsW-1] ? SatMin : SatMax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.curve_x = r_out_x;
    assign o_res.curve_y = r_out_y;

    // weights of one curve point add up to one within rounding
    always_comb begin
        wq_sum = '0;
        for (int k = 0; k < Lanes; k++) begin
            wq_sum = wq_sum + RsW'($signed(r4_wq[k]));
        end
    end

    `CRCV_ASSERT_IMP(a_weight_sum, i_clk, i_rst_n, r4_vld,
        (wq_sum >= $signed(RsW'(WqOne) - RsW'(2)) && wq_sum <= $signed(RsW'(WqOne) + RsW'(2))),
        "blend weights do not sum to one")

    `CRCV_ASSERT_IMP(a_weight_sign, i_clk, i_rst_n, r4_vld,
        (!r4_wq[1][WqW-1] && !r4_wq[2][WqW-1] && (r4_wq[0][WqW-1] || r4_wq[0] == '0) && (r4_wq[3][WqW-1] || r4_wq[3] == '0)),
        "blend weight has the wrong sign")

    `CRCV_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r5_vld && !en5,
        (r5_vld && $stable(r5_prdx) && $stable(r5_prdy)),
        "product stage changed while stalled")

endmodule

FILE: sv/catmull_rom_curve_point.sv
// Catmull-Rom curve point evaluator over a table of 256 two-dimensional control points.
// i_req carries one item per valid/ready handshake. req_type load writes point_x and
// point_y into slot point_index and gives no result; req_type evaluate blends the four
// points starting at start_offset plus the span picked by curve_t and segment_points,
// with indices wrapped once by point_count, and gives one item on o_res.
// i_cfg writes point_count; it is taken at once and must only change while idle.
// One item is taken every cycle while o_res is ready: six register stages (span split,
// table fetch, cube, weights, products, sum with rounding and saturation) each hold one
// item, and each table lane has its own copy of the table so the four points come from
// four single-port reads.
// Loads are written into the table in the fetch stage, in order with the reads of
// evaluations around them.
// Reset empties the pipeline and sets point_count to four; table contents are kept
// and a slot must be loaded before an evaluation reads it.
// When o_res is not ready, stages fill up behind the output register and i_req.ready
// falls only once every stage holds an item; nothing is dropped or repeated.
module catmull_rom_curve_point
    import crcv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    crcv_cfg_if.sink  i_cfg,
    crcv_req_if.sink  i_req,
    crcv_res_if.source o_res
);

    logic [LenW-1:0] r_pc;
    logic            s1_vld;
    t_span_item      s1;
    logic            s1_rdy;
    logic            s2_vld;
    t_fetch_item     s2;
    logic            s2_rdy;

    // point count register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PointCountRst;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_pc <= i_cfg.point_count;
        end
    end

    crcv_span u_span (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_s1_vld (s1_vld),
        .o_s1     (s1),
        .i_s1_rdy (s1_rdy)
    );

    crcv_fetch u_fetch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_point_count (r_pc),
        .i_s1_vld      (s1_vld),
        .i_s1          (s1),
        .o_s1_rdy      (s1_rdy),
        .o_s2_vld      (s2_vld),
        .o_s2          (s2),
        .i_s2_rdy      (s2_rdy)
    );

    crcv_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s2_vld (s2_vld),
        .i_s2     (s2),
        .o_s2_rdy (s2_rdy),
        .o_res    (o_res)
    );

endmodule
